// ----- hw/rtl/pecl_pkg.sv -----
// shared types and command codes for the page entry cache
package pecl_pkg;

    localparam int unsigned SLOTS   = 8;
    localparam int unsigned KEY_W   = 20;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned HITS_W  = 8;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CELL_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

    localparam logic [HITS_W-1:0] HITS_LIMIT_RESET = 8'd255;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   page_index;
        logic [VALUE_W-1:0] entry_value;
    } pecl_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] lookup_value;
        logic               hit;
    } pecl_out_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [HITS_W-1:0]  limit;
    } pecl_bcast_t;

    typedef struct packed {
        logic               active;
        logic               found;
        logic [VALUE_W-1:0] value;
        logic [HITS_W-1:0]  min_hits;
        logic [CELL_W-1:0]  min_idx;
    } pecl_carry_t;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] idx;
    } pecl_fill_t;

endpackage

// ----- hw/rtl/page_entry_cache_lfu.sv -----
// Fully associative page entry cache with least-frequently-used replacement. One item at a
// time: an accepted item starts a token that walks the row of SLOTS cells, one cell per
// cycle, matching keys, raising hit counters, clearing invalidated slots and tracking the
// slot with fewest hits; a fill is written to that slot once the walk ends. The block takes no new
// item until the walk and the last state are through, as it is ready only when idle. The
// result sits in an output register, so a waiting result does not stop the next item from
// being accepted, but that item's fill and result then wait in the last state until the
// register has been taken.
module page_entry_cache_lfu (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pecl_pkg::pecl_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pecl_pkg::pecl_out_t  out_data,
    input  logic                 hits_limit_we,
    input  logic [7:0]           hits_limit_wdata
);
    import pecl_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t             state_reg;
    pecl_in_t           item_reg;
    logic               start_reg;
    logic [HITS_W-1:0]  limit_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic [CELL_W-1:0]  res_idx_reg;
    logic               out_valid_reg;
    pecl_out_t          out_data_reg;

    pecl_bcast_t bcast;
    pecl_fill_t  fill;
    pecl_carry_t carry [SLOTS+1];
    logic        out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign bcast.cmd   = item_reg.cmd;
    assign bcast.key   = item_reg.page_index;
    assign bcast.value = item_reg.entry_value;
    assign bcast.limit = limit_reg;

    assign fill.we  = (state_reg == ST_DONE) && out_free && (item_reg.cmd == CMD_FILL)
                      && (item_reg.entry_value != '0);
    assign fill.idx = res_idx_reg;

    assign carry[0].active   = start_reg;
    assign carry[0].found    = 1'b0;
    assign carry[0].value    = '0;
    assign carry[0].min_hits = '0;
    assign carry[0].min_idx  = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        pecl_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bcast     (bcast),
            .fill      (fill),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            start_reg     <= 1'b0;
            limit_reg     <= HITS_LIMIT_RESET;
            res_value_reg <= '0;
            res_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            start_reg <= (state_reg == ST_IDLE) && in_valid;
            if (hits_limit_we)
            begin
                limit_reg <= hits_limit_wdata;
            end
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (carry[SLOTS].active)
                    begin
                        res_value_reg <= carry[SLOTS].value;
                        res_idx_reg   <= carry[SLOTS].min_idx;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg.lookup_value <= res_value_reg;
                        out_data_reg.hit          <= (res_value_reg != '0);
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/pecl_cell.sv -----
// one cache slot with its stage of the scan token
module pecl_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pecl_pkg::pecl_bcast_t bcast,
    input  pecl_pkg::pecl_fill_t  fill,
    input  pecl_pkg::pecl_carry_t carry_in,
    output pecl_pkg::pecl_carry_t carry_out
);
    import pecl_pkg::*;

    localparam logic [CELL_W-1:0] MY_IDX = CELL_W'(IDX);

    logic [KEY_W-1:0]   key_reg,   key_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [HITS_W-1:0]  hits_reg,  hits_next;
    pecl_carry_t        carry_reg, carry_next;
    logic               match;

    assign match     = (key_reg == bcast.key);
    assign carry_out = carry_reg;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        hits_next  = hits_reg;
        carry_next = carry_in;
        if (carry_in.active)
        begin
            case (bcast.cmd)
                CMD_LOOKUP:
                begin
                    if (!carry_in.found && match)
                    begin
                        carry_next.found = 1'b1;
                        carry_next.value = value_reg;
                        if (hits_reg < bcast.limit)
                        begin
                            hits_next = hits_reg + HITS_W'(1);
                        end
                    end
                end
                CMD_FILL:
                begin
                    if ((IDX == 0) || (hits_reg < carry_in.min_hits))
                    begin
                        carry_next.min_hits = hits_reg;
                        carry_next.min_idx  = MY_IDX;
                    end
                end
                CMD_INVAL:
                begin
                    if (match)
                    begin
                        key_next   = '0;
                        value_next = '0;
                        hits_next  = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (fill.we && (fill.idx == MY_IDX))
        begin
            key_next   = bcast.key;
            value_next = bcast.value;
            hits_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            value_reg <= '0;
            hits_reg  <= '0;
            carry_reg <= '0;
        end
        else
        begin
            key_reg   <= key_next;
            value_reg <= value_next;
            hits_reg  <= hits_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ----- hw/rtl/pecl_checker.sv -----
// port-level checks for the page entry cache, bound to the top level
module pecl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input pecl_pkg::pecl_out_t out_data
);
    import pecl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.hit == (out_data.lookup_value != '0)))
        else $error("hit flag disagrees with lookup value");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("ready again too soon after an item");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared right after an item was taken");

endmodule

bind page_entry_cache_lfu pecl_checker u_pecl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
